// File: rtl/orca_count_min_sketch_assert.svh
// Assertion macros for the count-min sketch checker.
`ifndef ORCA_COUNT_MIN_SKETCH_ASSERT_SVH
`define ORCA_COUNT_MIN_SKETCH_ASSERT_SVH

// Same-cycle implication.
`define OCMS_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication.
`define OCMS_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: rtl/ocms_pkg.sv
// Shared constants and types for the count-min sketch.
`timescale 1ns / 1ps

package ocms_pkg;

   // store sizes
   localparam int SKETCH_DEPTH = 4096;
   localparam int TABLE_DEPTH  = 4096;
   localparam int MAX_COUNTERS = 16;

   localparam int SK_AW  = $clog2(SKETCH_DEPTH);
   localparam int TAB_AW = $clog2(TABLE_DEPTH);
   localparam int NUM_W  = $clog2(MAX_COUNTERS + 1);

   // beat field widths
   localparam int TYPE_W  = 2;
   localparam int HASH_W  = 32;
   localparam int TADDR_W = 12;
   localparam int TDATA_W = 8;
   localparam int COUNT_W = 32;

   // register widths
   localparam int BB_W       = 4;
   localparam int BS_W       = 9;
   localparam int CPI_W      = 5;
   localparam int OC_W       = 13;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 13;

   localparam int BUCKET_W  = (1 << BB_W) - 1;
   localparam int ROW_W     = OC_W;
   localparam int DIV_CNT_W = $clog2(HASH_W);

   // request codes
   localparam logic [TYPE_W-1:0] REQ_INC    = 2'd0;
   localparam logic [TYPE_W-1:0] REQ_QUERY  = 2'd1;
   localparam logic [TYPE_W-1:0] REQ_TWRITE = 2'd2;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_BUCKET_BITS = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_BUCKET_LEN  = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_CNT_PER_ITM = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_OPTION_CNT  = 2'd3;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_DIV,
      ST_TRD,
      ST_CRD,
      ST_CWR,
      ST_FIN
   } state_type;

endpackage

// File: rtl/orca_count_min_sketch.sv
// Count-min sketch top level: sequencer, divider, table and counter store.
`timescale 1ns / 1ps

// Bucketed count-min sketch. A request beat carries a precomputed 32-bit key hash.
// The low bucket_bits of the hash pick a bucket (base = index * bucket length); the
// hash bits above, modulo (option_count - 1), pick a row of the combination table,
// whose counters_per_item entries are offsets into the bucket. An increment adds
// one (wrapping) to each listed counter; a query answers the smallest of them, or
// all ones when none are listed; a table write stores one offset and answers
// nothing. After reset the counter store is cleared one entry a cycle, and req_stall
// stays high until the whole store is clear. A table write leaves the sequencer idle.
// An increment or query first works out the row remainder bit-serially (one quotient
// bit a cycle through a single subtract-and-compare), or skips it when the modulus is
// zero; then it does a read-modify-write per counter (table read, counter read, then
// update) for N counters, where N is counters_per_item (capped at 16). A query then
// moves its answer to the result register, waiting while an earlier answer still
// waits there on rsp_stall. With N zero there is neither remainder nor store pass: an
// increment leaves the sequencer idle and a query goes straight to the result register.
// Query results sit in an output register, so the next request is taken while a result
// still waits on rsp_stall. Registers may be written at any time while the block is
// idle; csr_ready is always high.

module orca_count_min_sketch (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_stall,
   input  logic [ocms_pkg::TYPE_W-1:0]      req_type,
   input  logic [ocms_pkg::HASH_W-1:0]      req_key_hash,
   input  logic [ocms_pkg::TADDR_W-1:0]     req_table_addr,
   input  logic [ocms_pkg::TDATA_W-1:0]     req_table_data,
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output logic [ocms_pkg::COUNT_W-1:0]     rsp_min_count,
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic [ocms_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [ocms_pkg::CSR_DATA_W-1:0]  csr_data
);
   import ocms_pkg::*;

   // configuration registers
   logic [BB_W-1:0]  bb_ff;
   logic [BS_W-1:0]  bs_ff;
   logic [CPI_W-1:0] cpi_ff;
   logic [OC_W-1:0]  oc_ff;

   // sequencer
   state_type state_ff, state_in;

   // per-request working registers
   logic                 query_ff, query_in;
   logic [HASH_W-1:0]    dvd_ff, dvd_in;
   logic [ROW_W-1:0]     rem_ff, rem_in;
   logic [ROW_W-1:0]     mod_ff, mod_in;
   logic [DIV_CNT_W-1:0] dcnt_ff, dcnt_in;
   logic [SK_AW-1:0]     base_ff, base_in;
   logic [NUM_W-1:0]     num_ff, num_in;
   logic [NUM_W-1:0]     idx_ff, idx_in;
   logic [SK_AW-1:0]     cidx_ff, cidx_in;
   logic [COUNT_W-1:0]   min_ff, min_in;
   logic [SK_AW-1:0]     clr_ff, clr_in;

   // result register
   logic               rsp_valid_ff;
   logic [COUNT_W-1:0] rsp_data_ff;
   logic               out_load;

   // stores
   logic [TDATA_W-1:0] tab_mem [TABLE_DEPTH];
   logic [TDATA_W-1:0] tab_rd_ff;
   logic               tab_we;
   logic [TAB_AW-1:0]  tab_waddr;
   logic [TAB_AW-1:0]  tab_raddr;

   logic [COUNT_W-1:0] cnt_mem [SKETCH_DEPTH];
   logic [COUNT_W-1:0] cnt_rd_ff;
   logic               cnt_we;
   logic [SK_AW-1:0]   cnt_waddr;
   logic [COUNT_W-1:0] cnt_wdata;

   // request decode helpers
   logic                    req_acc;
   logic [BUCKET_W-1:0]     bucket;
   logic [BS_W+BUCKET_W-1:0] base_prod;
   logic [ROW_W-1:0]        mod_calc;
   logic [31:0]             cpi_ext;
   logic [NUM_W-1:0]        num_calc;
   logic [31:0]             taddr_ext;
   logic [31:0]             wr_addr_ext;
   logic [31:0]             idx_sum;
   logic [ROW_W:0]          rem_sh;
   logic [ROW_W:0]          rem_sub;

   assign csr_ready     = 1'b1;
   assign req_stall     = (state_ff != ST_IDLE);
   assign req_acc       = req_valid && !req_stall;
   assign rsp_valid     = rsp_valid_ff;
   assign rsp_min_count = rsp_data_ff;

   // bucket base, modulus and counter count, worked out as the beat is taken
   assign bucket    = req_key_hash[BUCKET_W-1:0] & ~({BUCKET_W{1'b1}} << bb_ff);
   assign base_prod = (BS_W+BUCKET_W)'(bs_ff) * (BS_W+BUCKET_W)'(bucket);
   assign mod_calc  = (oc_ff == '0) ? '0 : oc_ff - ROW_W'(1);
   assign cpi_ext   = 32'(cpi_ff);
   assign num_calc  = (cpi_ext > MAX_COUNTERS) ? NUM_W'(MAX_COUNTERS) : NUM_W'(cpi_ext);

   // table row address: row * counters_per_item + entry, wrapping on the table
   assign taddr_ext   = 32'(rem_ff) * 32'(cpi_ff) + 32'(idx_ff);
   assign tab_raddr   = taddr_ext[TAB_AW-1:0];
   assign wr_addr_ext = 32'(req_table_addr);
   assign tab_waddr   = wr_addr_ext[TAB_AW-1:0];

   // counter index: bucket base plus offset, wrapping on the store
   assign idx_sum = 32'(base_ff) + 32'(tab_rd_ff);

   // restoring remainder step, one hash bit a cycle
   assign rem_sh  = {rem_ff, dvd_ff[HASH_W-1]};
   assign rem_sub = rem_sh - {1'b0, mod_ff};

   always_comb begin
      state_in  = state_ff;
      query_in  = query_ff;
      dvd_in    = dvd_ff;
      rem_in    = rem_ff;
      mod_in    = mod_ff;
      dcnt_in   = dcnt_ff;
      base_in   = base_ff;
      num_in    = num_ff;
      idx_in    = idx_ff;
      cidx_in   = cidx_ff;
      min_in    = min_ff;
      clr_in    = clr_ff;
      tab_we    = 1'b0;
      cnt_we    = 1'b0;
      cnt_waddr = cidx_ff;
      cnt_wdata = cnt_rd_ff + COUNT_W'(1);
      out_load  = 1'b0;

      case (state_ff)
         ST_CLEAR: begin
            cnt_we    = 1'b1;
            cnt_waddr = clr_ff;
            cnt_wdata = '0;
            clr_in    = clr_ff + SK_AW'(1);
            if (clr_ff == SK_AW'(SKETCH_DEPTH - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_acc) begin
               case (req_type)
                  REQ_INC, REQ_QUERY: begin
                     query_in = (req_type == REQ_QUERY);
                     dvd_in   = req_key_hash >> bb_ff;
                     rem_in   = '0;
                     mod_in   = mod_calc;
                     dcnt_in  = '0;
                     base_in  = base_prod[SK_AW-1:0];
                     num_in   = num_calc;
                     idx_in   = '0;
                     min_in   = '1;
                     if (num_calc == '0) begin
                        state_in = (req_type == REQ_QUERY) ? ST_FIN : ST_IDLE;
                     end else if (mod_calc == '0) begin
                        state_in = ST_TRD;
                     end else begin
                        state_in = ST_DIV;
                     end
                  end
                  REQ_TWRITE: begin
                     tab_we = 1'b1;
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_DIV: begin
            rem_in  = (rem_sh >= {1'b0, mod_ff}) ? rem_sub[ROW_W-1:0] : rem_sh[ROW_W-1:0];
            dvd_in  = dvd_ff << 1;
            dcnt_in = dcnt_ff + DIV_CNT_W'(1);
            if (dcnt_ff == DIV_CNT_W'(HASH_W - 1)) begin
               state_in = ST_TRD;
            end
         end
         ST_TRD: begin
            state_in = ST_CRD;
         end
         ST_CRD: begin
            cidx_in  = idx_sum[SK_AW-1:0];
            state_in = ST_CWR;
         end
         ST_CWR: begin
            if (query_ff) begin
               min_in = (cnt_rd_ff < min_ff) ? cnt_rd_ff : min_ff;
            end else begin
               cnt_we = 1'b1;
            end
            idx_in = idx_ff + NUM_W'(1);
            if (idx_in == num_ff) begin
               state_in = query_ff ? ST_FIN : ST_IDLE;
            end else begin
               state_in = ST_TRD;
            end
         end
         ST_FIN: begin
            out_load = !rsp_valid_ff || !rsp_stall;
            if (out_load) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
         clr_ff   <= '0;
      end else begin
         state_ff <= state_in;
         clr_ff   <= clr_in;
      end
   end

   always_ff @(posedge clock) begin
      query_ff <= query_in;
      dvd_ff   <= dvd_in;
      rem_ff   <= rem_in;
      mod_ff   <= mod_in;
      dcnt_ff  <= dcnt_in;
      base_ff  <= base_in;
      num_ff   <= num_in;
      idx_ff   <= idx_in;
      cidx_ff  <= cidx_in;
      min_ff   <= min_in;
   end

   // configuration writes, one register a beat
   always_ff @(posedge clock) begin
      if (reset) begin
         bb_ff  <= BB_W'(4);
         bs_ff  <= BS_W'(16);
         cpi_ff <= CPI_W'(2);
         oc_ff  <= OC_W'(1);
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_BUCKET_BITS: bb_ff  <= csr_data[BB_W-1:0];
            CSR_BUCKET_LEN:  bs_ff  <= csr_data[BS_W-1:0];
            CSR_CNT_PER_ITM: cpi_ff <= csr_data[CPI_W-1:0];
            CSR_OPTION_CNT:  oc_ff  <= csr_data[OC_W-1:0];
            default: begin
            end
         endcase
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (out_load) begin
         rsp_data_ff <= min_ff;
      end
   end

   // combination table
   always_ff @(posedge clock) begin
      if (tab_we) begin
         tab_mem[tab_waddr] <= req_table_data;
      end
      tab_rd_ff <= tab_mem[tab_raddr];
   end

   // counter store
   always_ff @(posedge clock) begin
      if (cnt_we) begin
         cnt_mem[cnt_waddr] <= cnt_wdata;
      end
      cnt_rd_ff <= cnt_mem[cidx_in];
   end

endmodule

// File: rtl/ocms_checker.sv
// Port-level assertion checker for the count-min sketch, bound to the top level.
`timescale 1ns / 1ps
`include "orca_count_min_sketch_assert.svh"

module ocms_checker (
   input logic                             clock,
   input logic                             reset,
   input logic                             req_valid,
   input logic                             req_stall,
   input logic [ocms_pkg::TYPE_W-1:0]      req_type,
   input logic [ocms_pkg::HASH_W-1:0]      req_key_hash,
   input logic [ocms_pkg::TADDR_W-1:0]     req_table_addr,
   input logic [ocms_pkg::TDATA_W-1:0]     req_table_data,
   input logic                             rsp_valid,
   input logic                             rsp_stall,
   input logic [ocms_pkg::COUNT_W-1:0]     rsp_min_count,
   input logic                             csr_valid,
   input logic                             csr_ready,
   input logic [ocms_pkg::CSR_IDX_W-1:0]   csr_index,
   input logic [ocms_pkg::CSR_DATA_W-1:0]  csr_data
);
   import ocms_pkg::*;

   logic req_acc;
   assign req_acc = req_valid && !req_stall;

   // a held result beat keeps its value
   `OCMS_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_min_count), "result beat changed while stalled")

   // store clear keeps requests out straight after reset
   `OCMS_ASSERT_SAME(a_clear_stall, clock, reset, $past(reset), req_stall, "request taken during store clear")

   // a query always occupies the sequencer
   `OCMS_ASSERT_NEXT(a_query_busy, clock, reset, req_acc && (req_type == REQ_QUERY), req_stall, "query did not occupy the sequencer")

   // a table write leaves the sequencer free for the next request
   `OCMS_ASSERT_NEXT(a_twrite_quick, clock, reset, req_acc && (req_type == REQ_TWRITE), !req_stall, "table write held the sequencer")

   // an increment never produces a result beat
   `OCMS_ASSERT_NEXT(a_inc_silent, clock, reset, req_acc && (req_type == REQ_INC) && !rsp_valid, !rsp_valid, "increment produced a result")

endmodule

bind orca_count_min_sketch ocms_checker u_ocms_checker (.*);
